// ===== hdl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge of i_clk outside reset.
`define ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked on every rising edge of i_clk outside reset.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hdl/gnms_pkg.sv =====
`default_nettype none
package gnms_pkg;
    localparam int MAX_WIDTH = 1024;
    localparam int ADDR_W    = $clog2(MAX_WIDTH);
    localparam int WIDTH_W   = 11;
    localparam int ROW_W     = 12;
    localparam int EDGEL_W   = 20;
    localparam int PADDR_W   = 3;

    localparam logic [PADDR_W-1:0] REG_IMAGE_WIDTH = 3'd0;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_PREP,
        S_MUL,
        S_DONE
    } t_state;

    // One line store entry: upper magnitude, centre magnitude, centre direction.
    typedef struct packed {
        logic [15:0] upper;
        logic [15:0] centre;
        logic [31:0] dir;
    } t_entry;

    // Window column: [0] top, [1] middle, [2] bottom.
    typedef logic [2:0][15:0] t_col;
endpackage
`default_nettype wire

// ===== hdl/gnms_in_if.sv =====
`default_nettype none
interface gnms_in_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [15:0] magnitude;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;

    modport source (output valid, mode, magnitude, dir_x, dir_y, input ready);
    modport sink   (input valid, mode, magnitude, dir_x, dir_y, output ready);
endinterface
`default_nettype wire

// ===== hdl/gnms_out_if.sv =====
`default_nettype none
interface gnms_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] strength;
    logic [9:0]  column;
    logic [9:0]  row;
    logic [19:0] edgel_index;

    modport source (output valid, strength, column, row, edgel_index, input ready);
    modport sink   (input valid, strength, column, row, edgel_index, output ready);
endinterface
`default_nettype wire

// ===== hdl/gradient_non_max_suppression_top.sv =====
// Gradient non-maximum suppression over a raster-order pixel stream.
// Pixels enter on i_pix (valid/ready); a transaction carries mode, magnitude
// and the signed x/y gradient. A mode of one is a flush transaction that acts
// as a zero pixel; one row of flush transactions plus one more drains the
// last image row. Local maxima leave on o_edgel with strength, column, row
// and a running edgel index. The row width is set through the APB register
// image_width at address 0, clamped to 3..1024; the user must write it only
// while idle, as the block does not enforce this. A pixel passes accept, line
// store read and write-back, direction decode, five products on the single
// shared 16x16 multiplier and compare, which loads the output register once
// it is free. The centre a pixel judges lies one row and one column behind
// it, or for column zero is the last centre of the row two above. After reset
// the line store memory is cleared one entry per cycle with ready held low;
// APB writes are taken during that pass. When the receiver stalls, a waiting
// result sits in the output register while the next pixel is accepted and
// worked; only a second result finding the register full holds the block.
`default_nettype none
module gradient_non_max_suppression_top
    import gnms_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    gnms_in_if.sink                 i_pix,
    gnms_out_if.source              o_edgel,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    // Line stores: one entry per column holds both magnitude lines and the
    // centre direction line, so one read and one write serve a pixel.
    t_entry r_mem [MAX_WIDTH];
    t_entry r_rd;

    t_state r_state, n_state;
    logic [ADDR_W-1:0]  r_clr;
    logic [WIDTH_W-1:0] r_image_width;
    logic [ADDR_W-1:0]  r_col;
    logic [ROW_W-1:0]   r_row;
    logic [EDGEL_W-1:0] r_edgel_count;

    // Accepted pixel, with flush already turned into zeros.
    logic [15:0] r_mag;
    logic [31:0] r_dir;

    // The two most recent window columns and the direction held for the centre.
    t_col        r_w1, r_w2;
    logic [31:0] r_held_dir;

    // Evaluation operands.
    t_col        r_lc, r_cc, r_rc;
    logic [31:0] r_edir;
    logic        r_eval;
    logic [15:0] r_cmag;
    logic [9:0]  r_ccol;
    logic [9:0]  r_crow;

    logic        r_ok;
    logic [15:0] r_num, r_den, r_dn;
    logic [15:0] r_p1a, r_p2a, r_p1b, r_p2b, r_cm;
    logic [2:0]  r_k;
    logic [32:0] r_acc_a, r_acc_b;
    logic [31:0] r_s;

    logic        r_out_valid;
    logic [15:0] r_out_strength;
    logic [9:0]  r_out_column;
    logic [9:0]  r_out_row;
    logic [19:0] r_out_index;

    logic               w_accept;
    logic [WIDTH_W-1:0] w_eff;
    logic               w_pre, w_post;
    logic               w_we;
    logic [ADDR_W-1:0]  w_waddr;
    t_entry             w_wdata;
    logic               w_hit, w_out_free;
    logic               w_cfg_wr;

    assign w_accept = i_pix.valid && i_pix.ready;
    assign i_pix.ready = (r_state == S_IDLE);
    assign w_cfg_wr = psel && penable && pwrite && (paddr == REG_IMAGE_WIDTH);

    assign pready = 1'b1;
    assign prdata = (paddr == REG_IMAGE_WIDTH) ? {21'd0, r_image_width} : 32'd0;

    always_comb begin
        w_eff = r_image_width;
        if (r_image_width < WIDTH_W'(3)) begin
            w_eff = WIDTH_W'(3);
        end else if (r_image_width > WIDTH_W'(MAX_WIDTH)) begin
            w_eff = WIDTH_W'(MAX_WIDTH);
        end
    end

    // Column zero finishes the last centre of the row two above; any other
    // column finishes the centre just to its upper left.
    assign w_pre  = (r_col == '0) && (r_row >= ROW_W'(2));
    assign w_post = (r_col != '0) && (r_row >= ROW_W'(1));

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_col;
        w_wdata = '0;
        if (r_state == S_CLEAR) begin
            w_we    = 1'b1;
            w_waddr = r_clr;
        end else if (r_state == S_READ) begin
            w_we    = 1'b1;
            w_wdata = '{upper: r_rd.centre, centre: r_mag, dir: r_dir};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (w_accept) begin
            r_rd <= r_mem[r_col];
        end
    end

    // Decision: the blends must both fall strictly below den * centre.
    assign w_hit      = r_ok && (r_acc_a < {1'b0, r_s}) && (r_acc_b < {1'b0, r_s});
    assign w_out_free = !r_out_valid || o_edgel.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr == ADDR_W'(MAX_WIDTH - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (w_accept) n_state = S_READ;
            end
            S_READ: n_state = S_PREP;
            S_PREP: n_state = S_MUL;
            S_MUL: begin
                if (r_k == 3'd4) n_state = S_DONE;
            end
            S_DONE: begin
                if (!w_hit || w_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr         <= '0;
            r_image_width <= WIDTH_W'(MAX_WIDTH);
            r_col         <= '0;
            r_row         <= '0;
            r_edgel_count <= '0;
            r_out_valid   <= 1'b0;
            r_k           <= '0;
            r_w1          <= '0;
            r_w2          <= '0;
            r_held_dir    <= '0;
        end else begin
            if (r_state == S_CLEAR) r_clr <= r_clr + ADDR_W'(1);
            if (w_cfg_wr) r_image_width <= pwdata[WIDTH_W-1:0];
            if (r_state == S_READ) begin
                r_w1       <= r_w2;
                r_w2       <= {r_mag, r_rd.centre, r_rd.upper};
                r_held_dir <= r_rd.dir;
                if ({1'b0, r_col} + WIDTH_W'(1) >= w_eff) begin
                    r_col <= '0;
                    if (r_row != '1) r_row <= r_row + ROW_W'(1);
                end else begin
                    r_col <= r_col + ADDR_W'(1);
                end
            end
            if (r_state == S_PREP) r_k <= '0;
            else if (r_state == S_MUL) r_k <= r_k + 3'd1;
            if (r_state == S_DONE && w_hit && w_out_free) begin
                r_out_valid <= 1'b1;
                if (r_edgel_count != '1) r_edgel_count <= r_edgel_count + EDGEL_W'(1);
            end else if (o_edgel.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath.
    logic signed [16:0] v_dx, v_dy, v_ax;
    logic [15:0] v_num, v_den, v_p1a, v_p2a, v_p1b, v_p2b;
    logic [15:0] v_opa, v_opb;
    logic [31:0] v_prod;

    always_comb begin
        v_dx = {r_edir[15], r_edir[15:0]};
        v_dy = {r_edir[31], r_edir[31:16]};
        if (v_dy < 0) begin
            v_dx = -v_dx;
            v_dy = -v_dy;
        end
        v_ax = -v_dx;
        if (v_dx > 0) begin
            if (v_dx > v_dy) begin
                v_den = v_dx[15:0]; v_num = v_dy[15:0];
                v_p1a = r_lc[0]; v_p2a = r_lc[1]; v_p1b = r_rc[2]; v_p2b = r_rc[1];
            end else begin
                v_den = v_dy[15:0]; v_num = v_dx[15:0];
                v_p1a = r_lc[0]; v_p2a = r_cc[0]; v_p1b = r_rc[2]; v_p2b = r_cc[2];
            end
        end else if (v_dy > v_ax) begin
            v_den = v_dy[15:0]; v_num = v_ax[15:0];
            v_p1a = r_lc[2]; v_p2a = r_cc[2]; v_p1b = r_rc[0]; v_p2b = r_cc[0];
        end else begin
            v_den = v_ax[15:0]; v_num = v_dy[15:0];
            v_p1a = r_rc[0]; v_p2a = r_rc[1]; v_p1b = r_lc[2]; v_p2b = r_lc[1];
        end
    end

    always_comb begin
        case (r_k)
            3'd0:    begin v_opa = r_num; v_opb = r_p1a; end
            3'd1:    begin v_opa = r_dn;  v_opb = r_p2a; end
            3'd2:    begin v_opa = r_num; v_opb = r_p1b; end
            3'd3:    begin v_opa = r_dn;  v_opb = r_p2b; end
            default: begin v_opa = r_den; v_opb = r_cm;  end
        endcase
        v_prod = v_opa * v_opb;
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mag <= i_pix.mode ? 16'd0 : i_pix.magnitude;
            r_dir <= i_pix.mode ? 32'd0 : {i_pix.dir_y, i_pix.dir_x};
        end
        if (r_state == S_READ) begin
            // Column left of column zero reads zero; the right column is
            // outside the image when the row end is being finished.
            r_lc   <= (w_post && r_col == ADDR_W'(1)) ? '0 : r_w1;
            r_cc   <= r_w2;
            r_rc   <= w_post ? {r_mag, r_rd.centre, r_rd.upper} : '0;
            r_edir <= r_held_dir;
            r_eval <= w_pre || w_post;
            r_cmag <= r_w2[1];
            if (w_pre) begin
                r_ccol <= 10'(w_eff - WIDTH_W'(1));
                r_crow <= (r_row - ROW_W'(2) > ROW_W'(1023)) ? 10'd1023
                                                             : 10'(r_row - ROW_W'(2));
            end else begin
                r_ccol <= 10'(r_col - ADDR_W'(1));
                r_crow <= (r_row - ROW_W'(1) > ROW_W'(1023)) ? 10'd1023
                                                             : 10'(r_row - ROW_W'(1));
            end
        end
        if (r_state == S_PREP) begin
            r_num <= v_num;
            r_den <= v_den;
            r_dn  <= v_den - v_num;
            r_p1a <= v_p1a;
            r_p2a <= v_p2a;
            r_p1b <= v_p1b;
            r_p2b <= v_p2b;
            r_cm  <= r_cc[1];
            // A zero direction or a zero centre is never an edgel.
            r_ok  <= r_eval && (r_cc[1] != 16'd0) && (v_den != 16'd0);
        end
        if (r_state == S_MUL) begin
            case (r_k)
                3'd0:    r_acc_a <= {1'b0, v_prod};
                3'd1:    r_acc_a <= r_acc_a + {1'b0, v_prod};
                3'd2:    r_acc_b <= {1'b0, v_prod};
                3'd3:    r_acc_b <= r_acc_b + {1'b0, v_prod};
                default: r_s     <= v_prod;
            endcase
        end
        if (r_state == S_DONE && w_hit && w_out_free) begin
            r_out_strength <= r_cmag;
            r_out_column   <= r_ccol;
            r_out_row      <= r_crow;
            r_out_index    <= r_edgel_count;
        end
    end

    assign o_edgel.valid       = r_out_valid;
    assign o_edgel.strength    = r_out_strength;
    assign o_edgel.column      = r_out_column;
    assign o_edgel.row         = r_out_row;
    assign o_edgel.edgel_index = r_out_index;

`include "assert_macros.svh"
    `ASSERT_SAME(a_no_accept_in_clear, r_state == S_CLEAR, !i_pix.ready)
    `ASSERT_NEXT(a_accept_reads, w_accept, r_state == S_READ)
    `ASSERT_NEXT(a_result_loaded, r_state == S_DONE && w_hit && w_out_free,
                 r_out_valid && r_out_strength != 16'd0)
    `ASSERT_SAME(a_mul_step_range, r_state == S_MUL, r_k <= 3'd4)

endmodule
`default_nettype wire
